/* design/ucp_pkg.sv */
// Shared types, constants and the code point mapping for the UTF-8 to CP1251 transcoder.
package ucp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_OUT     = 4;

    localparam logic [10:0] CP_CYR_LO   = 11'h410;
    localparam logic [10:0] CP_CYR_HI   = 11'h44F;
    localparam logic [10:0] CP_IO_UPPER = 11'h401;
    localparam logic [10:0] CP_IO_LOWER = 11'h451;
    localparam logic [7:0]  CP_CYR_OFS  = 8'hB0;
    localparam logic [7:0]  CH_IO_UPPER = 8'hA8;
    localparam logic [7:0]  CH_IO_LOWER = 8'hB8;
    localparam logic [7:0]  CH_QUESTION = 8'h3F;

    // One queue entry: the output bytes caused by one input byte.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [1:0]              last_idx;
        logic                    last;
    } ucp_entry_t;

    // Both Cyrillic blocks sit at a fixed offset from their CP1251 codes
    // (0x410 -> 0xC0 and 0x430 -> 0xE0), so the low byte plus 0xB0 covers both.
    function automatic logic [7:0] map_cp(input logic [10:0] cp);
        logic [7:0] res;
        begin
            if (cp >= CP_CYR_LO && cp <= CP_CYR_HI) begin
                res = cp[7:0] + CP_CYR_OFS;
            end else if (cp == CP_IO_UPPER) begin
                res = CH_IO_UPPER;
            end else if (cp == CP_IO_LOWER) begin
                res = CH_IO_LOWER;
            end else begin
                res = CH_QUESTION;
            end
            return res;
        end
    endfunction

endpackage

/* design/ucp_front.sv */
// Front end: accepts bytes, decodes against the held lookahead and queues the output bytes.
module ucp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_byte_in,
    input  logic                s_end_of_string,
    input  logic                q_full,
    output logic                q_push,
    output ucp_pkg::ucp_entry_t q_entry
);

    logic [2:0][7:0] pend_reg;
    logic [2:0][7:0] pend_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    logic [3:0][7:0] cbuf;
    logic [3:0][7:0] obytes;
    logic [2:0]      len;
    logic [2:0]      pos;
    logic [2:0]      nout;
    logic            accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Held bytes first, then the new byte right after them.
    always_comb begin
        cbuf[0] = (count_reg == 2'd0) ? s_byte_in : pend_reg[0];
        cbuf[1] = (count_reg == 2'd1) ? s_byte_in : pend_reg[1];
        cbuf[2] = (count_reg == 2'd2) ? s_byte_in : pend_reg[2];
        cbuf[3] = s_byte_in;
        len     = {1'b0, count_reg} + 3'd1;
    end

    // Walk the at most four buffered bytes; each emitted byte consumes at least one.
    always_comb begin
        logic       stop;
        logic [7:0] c;
        logic [7:0] b;
        logic [7:0] ev;
        logic [2:0] r;
        logic [2:0] adv;
        logic [2:0] nxt;
        logic [2:0] rem;
        logic [2:0] idx;
        stop   = 1'b0;
        pos    = 3'd0;
        nout   = 3'd0;
        obytes = '0;
        c      = '0;
        b      = '0;
        ev     = '0;
        r      = '0;
        adv    = '0;
        nxt    = '0;
        for (int s = 0; s < 4; s++) begin
            if (!stop && pos < len) begin
                c   = cbuf[pos[1:0]];
                nxt = pos + 3'd1;
                b   = cbuf[nxt[1:0]];
                r   = len - pos;
                ev  = c;
                adv = 3'd1;
                priority if (!c[7]) begin
                    ev = c;
                end else if (c[7:5] == 3'b110) begin
                    if (r >= 3'd2) begin
                        if (b[7:6] == 2'b10) begin
                            ev  = ucp_pkg::map_cp({c[4:0], b[5:0]});
                            adv = 3'd2;
                        end
                    end else if (!s_end_of_string) begin
                        stop = 1'b1;
                    end
                end else if (c[7:4] == 4'b1110) begin
                    if (r >= 3'd3) begin
                        ev  = ucp_pkg::CH_QUESTION;
                        adv = 3'd3;
                    end else if (!s_end_of_string) begin
                        stop = 1'b1;
                    end
                end else if (c[7:3] == 5'b11110) begin
                    if (r >= 3'd4) begin
                        ev  = ucp_pkg::CH_QUESTION;
                        adv = 3'd4;
                    end else if (!s_end_of_string) begin
                        stop = 1'b1;
                    end
                end else begin
                    ev = c;
                end
                if (!stop) begin
                    obytes[nout[1:0]] = ev;
                    nout = nout + 3'd1;
                    pos  = pos + adv;
                end
            end
        end

        rem        = len - pos;
        count_next = (rem > 3'd3) ? 2'd3 : rem[1:0];
        for (int j = 0; j < 3; j++) begin
            idx          = pos + 3'(j);
            pend_next[j] = cbuf[idx[1:0]];
        end
    end

    assign q_push           = accept && (nout != 3'd0);
    assign q_entry.bytes    = obytes;
    assign q_entry.last_idx = 2'(nout - 3'd1);
    assign q_entry.last     = s_end_of_string;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= pend_next;
        end
    end

endmodule

/* design/ucp_queue.sv */
// Short first-word-fall-through queue of decoded entries between front and back.
module ucp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ucp_pkg::ucp_entry_t push_entry,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output ucp_pkg::ucp_entry_t head
);

    ucp_pkg::ucp_entry_t               mem_reg [ucp_pkg::QUEUE_DEPTH];
    logic [ucp_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [ucp_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [ucp_pkg::QCNT_W-1:0]        cnt_reg;
    logic                              do_push;
    logic                              do_pop;

    assign full       = (cnt_reg == ucp_pkg::QCNT_W'(ucp_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* design/ucp_back.sv */
// Back end: unpacks queued entries into single output bytes behind an output register.
module ucp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  ucp_pkg::ucp_entry_t head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_byte_out,
    output logic                m_last_out
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;
    logic       at_end;

    assign load   = head_valid && (!valid_reg || m_ready);
    assign at_end = (idx_reg == head.last_idx);
    assign pop    = load && at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= at_end ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= head.bytes[idx_reg];
            last_reg <= head.last && at_end;
        end
    end

    assign m_valid    = valid_reg;
    assign m_byte_out = byte_reg;
    assign m_last_out = last_reg;

endmodule

/* design/utf8_to_cp1251_stream.sv */
// Top level of the UTF-8 to Windows-1251 stream transcoder.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_byte_in[7:0], s_end_of_string
//   m_       out        m_valid/m_ready    m_byte_out[7:0], m_last_out
//
// One input byte is taken per cycle while the entry queue has room; each byte is
// decoded in the cycle it is accepted and its zero to four output bytes are queued.
// Output bytes leave one per cycle while m_ready allows, through the back end's output
// register, so an input byte that yields several outputs holds the back end until all are sent.
// Reset (aresetn low at a clock edge) empties the lookahead, the queue and the output.
module utf8_to_cp1251_stream (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       s_end_of_string,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte_out,
    output logic       m_last_out
);

    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_head_valid;
    ucp_pkg::ucp_entry_t q_in;
    ucp_pkg::ucp_entry_t q_head;

    ucp_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .s_end_of_string (s_end_of_string),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (q_in)
    );

    ucp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    ucp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_byte_out (m_byte_out),
        .m_last_out (m_last_out)
    );

endmodule

/* dv/utf8_cp1251_checker.sv */
// Checker for the UTF-8 to CP1251 transcoder: predicts output bytes and compares them.
module utf8_cp1251_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       s_end_of_string,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_byte_out,
    input  logic       m_last_out,
    output int         fail_count,
    output int         outstanding
);

    localparam logic [10:0] CP_A_UPPER  = 11'h410;
    localparam logic [10:0] CP_YA_UPPER = 11'h42F;
    localparam logic [10:0] CP_A_LOWER  = 11'h430;
    localparam logic [10:0] CP_YA_LOWER = 11'h44F;
    localparam logic [10:0] CP_YO_UPPER = 11'h401;
    localparam logic [10:0] CP_YO_LOWER = 11'h451;
    localparam logic [7:0]  CH_A_UPPER  = 8'hC0;
    localparam logic [7:0]  CH_A_LOWER  = 8'hE0;
    localparam logic [7:0]  CH_YO_UPPER = 8'hA8;
    localparam logic [7:0]  CH_YO_LOWER = 8'hB8;
    localparam logic [7:0]  CH_QMARK    = 8'h3F;
    localparam int          REPORT_MAX  = 10;

    typedef enum logic [2:0] {
        BC_ASCII,
        BC_LEAD2,
        BC_LEAD3,
        BC_LEAD4,
        BC_OTHER
    } byte_class_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       last_out;
    } cp1251_byte_t;

    cp1251_byte_t expected_bytes[$];
    logic [7:0]   lookahead[3];
    int unsigned  lookahead_n;
    int           fails;

    function automatic byte_class_t classify(input logic [7:0] b);
        if (!b[7])
            return BC_ASCII;
        else if (b[7:5] == 3'b110)
            return BC_LEAD2;
        else if (b[7:4] == 4'b1110)
            return BC_LEAD3;
        else if (b[7:3] == 5'b11110)
            return BC_LEAD4;
        return BC_OTHER;
    endfunction

    function automatic logic [7:0] cyrillic_to_cp1251(input logic [10:0] code);
        if (code >= CP_A_UPPER && code <= CP_YA_UPPER)
            return CH_A_UPPER + 8'(code - CP_A_UPPER);
        if (code >= CP_A_LOWER && code <= CP_YA_LOWER)
            return CH_A_LOWER + 8'(code - CP_A_LOWER);
        if (code == CP_YO_UPPER)
            return CH_YO_UPPER;
        if (code == CP_YO_LOWER)
            return CH_YO_LOWER;
        return CH_QMARK;
    endfunction

    // Decodes the held bytes plus the new one and queues the bytes they produce.
    // An incomplete lead stays held unless the string ends, when it goes out raw.
    task automatic transcode(input logic [7:0] in_byte, input logic eos);
        logic [7:0]   win[4];
        int unsigned  win_n;
        int unsigned  pos;
        int unsigned  room;
        int unsigned  need;
        int unsigned  j;
        logic         stall;
        byte_class_t  cls;
        cp1251_byte_t produced[$];
        for (j = 0; j < lookahead_n; j++)
            win[j] = lookahead[j];
        win[lookahead_n] = in_byte;
        win_n = lookahead_n + 1;
        pos = 0;
        stall = 1'b0;
        while (pos < win_n && !stall) begin
            room = win_n - pos;
            cls = classify(win[pos]);
            need = (cls == BC_LEAD2) ? 2 : (cls == BC_LEAD3) ? 3 : 4;
            if (cls == BC_ASCII || cls == BC_OTHER) begin
                produced.insert(produced.size(), cp1251_byte_t'{win[pos], 1'b0});
                pos++;
            end else if (room < need) begin
                if (!eos) begin
                    stall = 1'b1;
                end else begin
                    produced.insert(produced.size(), cp1251_byte_t'{win[pos], 1'b0});
                    pos++;
                end
            end else if (cls == BC_LEAD2) begin
                if (win[pos+1][7:6] == 2'b10) begin
                    produced.insert(produced.size(),
                                    cp1251_byte_t'{cyrillic_to_cp1251({win[pos][4:0],
                                                                       win[pos+1][5:0]}),
                                                   1'b0});
                    pos += 2;
                end else begin
                    produced.insert(produced.size(), cp1251_byte_t'{win[pos], 1'b0});
                    pos++;
                end
            end else begin
                // Three- and four-byte sequences are swallowed whole, whatever they hold.
                produced.insert(produced.size(), cp1251_byte_t'{CH_QMARK, 1'b0});
                pos += need;
            end
        end
        lookahead_n = 0;
        while (pos < win_n) begin
            lookahead[lookahead_n] = win[pos];
            lookahead_n++;
            pos++;
        end
        if (eos && produced.size() > 0)
            produced[produced.size()-1].last_out = 1'b1;
        foreach (produced[k])
            expected_bytes.insert(expected_bytes.size(), produced[k]);
    endtask

    initial begin
        fails = 0;
        lookahead_n = 0;
        fail_count = 0;
        outstanding = 0;
    end

    // Results are checked before the same edge's input transaction is predicted,
    // since a byte accepted now cannot leave the block at this edge.
    always @(posedge aclk) begin
        cp1251_byte_t exp_b;
        if (!aresetn) begin
            expected_bytes.delete();
            lookahead_n = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    if (fails < REPORT_MAX)
                        $display("unexpected output: byte_out %02h last_out %0b",
                                 m_byte_out, m_last_out);
                    fails++;
                end else begin
                    exp_b = expected_bytes.pop_front();
                    if (m_byte_out !== exp_b.byte_out || m_last_out !== exp_b.last_out) begin
                        if (fails < REPORT_MAX)
                            $display("mismatch: byte_out exp %02h got %02h, last_out exp %0b got %0b",
                                     exp_b.byte_out, m_byte_out, exp_b.last_out, m_last_out);
                        fails++;
                    end
                end
            end
            if (s_valid && s_ready)
                transcode(s_byte_in, s_end_of_string);
        end
        fail_count <= fails;
        outstanding <= expected_bytes.size();
    end

endmodule

/* dv/tb_utf8_to_cp1251_stream.sv */
// Testbench top for the UTF-8 to CP1251 transcoder: stimulus, flow control and verdict.
module tb_utf8_to_cp1251_stream;

    localparam int RANDOM_BYTES = 136;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 30;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_byte_in;
    logic       s_end_of_string;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_byte_out;
    logic       m_last_out;
    int         fail_count;
    int         outstanding;
    logic       src_burst;
    logic       snk_burst;
    logic [7:0] text[$];
    int         random_sent;

    utf8_to_cp1251_stream uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_out      (m_byte_out),
        .m_last_out      (m_last_out)
    );

    utf8_cp1251_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_out      (m_byte_out),
        .m_last_out      (m_last_out),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL");
        $finish;
    end

    // Holds the input side idle until the checker has seen every predicted byte.
    task automatic drain_outputs();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Called at the edge of the previous transaction; returns at the edge of this one.
    task automatic push_byte(input logic [7:0] b, input logic eos);
        int gap;
        if ($urandom_range(0, 11) == 0)
            src_burst = ~src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_in <= b;
        s_end_of_string <= eos;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_string(input logic [7:0] str[$], input logic allow_pause);
        foreach (str[i]) begin
            push_byte(str[i], i == str.size() - 1);
            // Pausing mid-string leaves a lead held inside the block while idle.
            if (allow_pause && $urandom_range(0, 24) == 0)
                drain_outputs();
        end
    endtask

    // Builds one string from well-formed tokens with some noise and an
    // occasional sequence cut short at the end.
    task automatic build_random_string(output logic [7:0] str[$]);
        int         tokens;
        int         kind;
        logic [10:0] code;
        str.delete();
        tokens = $urandom_range(1, 6);
        repeat (tokens) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                str.insert(str.size(), 8'($urandom_range(0, 127)));
            end else if (kind < 55) begin
                case ($urandom_range(0, 9))
                    0: code = 11'h401;
                    1: code = 11'h451;
                    default: code = 11'($urandom_range(11'h410, 11'h44F));
                endcase
                str.insert(str.size(), {3'b110, code[10:6]});
                str.insert(str.size(), {2'b10, code[5:0]});
            end else if (kind < 65) begin
                str.insert(str.size(), 8'($urandom_range(8'hC0, 8'hDF)));
                str.insert(str.size(), 8'($urandom_range(8'h80, 8'hBF)));
            end else if (kind < 75) begin
                str.insert(str.size(), 8'($urandom_range(8'hE0, 8'hEF)));
                repeat (2) str.insert(str.size(), 8'($urandom_range(0, 255)));
            end else if (kind < 83) begin
                str.insert(str.size(), 8'($urandom_range(8'hF0, 8'hF7)));
                repeat (3) str.insert(str.size(), 8'($urandom_range(0, 255)));
            end else begin
                str.insert(str.size(), 8'($urandom_range(0, 255)));
            end
        end
        if (str.size() > 1 && $urandom_range(0, 9) == 0)
            str.delete(str.size() - 1);
    endtask

    initial begin
        int stall;
        m_ready = 1'b0;
        snk_burst = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                snk_burst = ~snk_burst;
            stall = snk_burst ? 0 : $urandom_range(0, 7);
            repeat (stall) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_byte_in = 8'h00;
        s_end_of_string = 1'b0;
        src_burst = 1'b0;
        random_sent = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes of ASCII and the Cyrillic block boundaries.
        text = '{8'h00, 8'hD0, 8'h90, 8'hD1, 8'h8F, 8'h7F};
        send_string(text, 1'b0);
        // Last capitals and first lowercase, both Yo letters, and an overlong form.
        text = '{8'hD0, 8'hAF, 8'hD0, 8'hB0, 8'hD0, 8'h81, 8'hD1, 8'h91, 8'hC0, 8'h80};
        send_string(text, 1'b0);
        // Lead without continuation, a three-byte sequence, stray high bytes,
        // and a two-byte lead cut off by the end of the string.
        text = '{8'hD0, 8'h41, 8'hE2, 8'h82, 8'hAC, 8'h80, 8'hF8, 8'hD0};
        send_string(text, 1'b0);
        drain_outputs();
        // A four-byte sequence, then a truncated three-byte lead at the end.
        text = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF, 8'hE2, 8'h82};
        send_string(text, 1'b0);
        text = '{8'hF0, 8'h9F, 8'h98};
        send_string(text, 1'b0);

        while (random_sent < RANDOM_BYTES) begin
            build_random_string(text);
            send_string(text, 1'b1);
            random_sent += text.size();
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
